>>> hdl/tcds_pkg.sv
// Package for the tensor copy DMA scheduler: queue sizing, operation and
// result codes, and the packed input and result words.
// No dependencies.
package tcds_pkg;

  // Queue and chunk sizing.
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned CHUNK_BYTES = 16;
  localparam int unsigned MAX_DIMS    = 3;

  // Queue index and fill count widths.
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_STORE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Kinds of a result word.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_ACK   = 2'd3
  } kind_e;

  // One input word.
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] source_address;
    logic [63:0] dest_address;
    logic [7:0]  element_size;
    logic [1:0]  dim_count;
    logic [15:0] extent_a;
    logic [15:0] extent_b;
    logic [15:0] extent_c;
    logic [31:0] store_length;
    logic [15:0] sync_tag;
    logic [7:0]  pipe_tag;
    logic [7:0]  stage_tag;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [63:0] chunk_source;
    logic [63:0] chunk_dest;
    logic [4:0]  chunk_length;
    logic        request_done;
    logic [15:0] done_tag;
    logic [31:0] done_bytes;
    logic [7:0]  ready_pipe;
    logic [7:0]  ready_stage;
  } out_word_t;

endpackage

>>> hdl/tcds_size_mul.sv
// Byte count unit for tensor loads: element size times the used extents,
// kept to its low 32 bits. Depends on tcds_pkg.
module tcds_size_mul (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [7:0]  elem_size_i,
  input  logic [1:0]  dim_count_i,
  input  logic [15:0] extent_a_i,
  input  logic [15:0] extent_b_i,
  input  logic [15:0] extent_c_i,
  output logic [31:0] size_o
);
  import tcds_pkg::*;

  logic [1:0]  dims;
  logic [15:0] ext_a, ext_b, ext_c;
  logic [23:0] ab_q;
  logic [31:0] bc_q;

  // Unused dimensions count as an extent of one.
  always_comb begin
    dims  = (dim_count_i > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dim_count_i;
    ext_a = (dims >= 2'd1) ? extent_a_i : 16'd1;
    ext_b = (dims >= 2'd2) ? extent_b_i : 16'd1;
    ext_c = (dims >= 2'd3) ? extent_c_i : 16'd1;
  end

  // Two partial products, registered when a word is loaded.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ab_q <= 24'(elem_size_i) * 24'(ext_a);
      bc_q <= 32'(ext_b) * 32'(ext_c);
    end
  end

  // Final product of the registered partial products, low 32 bits only.
  assign size_o = 32'(ab_q) * bc_q;

endmodule

>>> hdl/tensor_copy_dma_scheduler_unit.sv
// Top level of the tensor copy DMA scheduler: load and store request queues
// held in synchronous memories, chunk issue and completion reporting.
// Depends on tcds_pkg and tcds_size_mul.
//
//   Channel  | Signals                        | Direction | Carries
//   ---------+--------------------------------+-----------+------------------------
//   input    | in_valid_i, in_stall_o, in_word_i    | in  | tick, enqueue or clear
//   result   | out_valid_o, out_stall_i, out_word_o | out | chunk, acknowledgment or none
//
// Each word is first accepted (the queue memories are read at their heads
// and the size partial products are registered), then executed, which
// writes the result register. Execution waits while a previous result is
// still stalled in the output register. Reset empties both queues and
// clears the progress counters at once; no clearing pass is needed.
module tensor_copy_dma_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcds_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcds_pkg::out_word_t out_word_o
);
  import tcds_pkg::*;

  localparam int unsigned SW = QCW + 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [63:0] src;
    logic [63:0] dst;
    logic [31:0] size;
    logic [31:0] tag;
  } ld_entry_t;

  typedef struct packed {
    logic [63:0] src;
    logic [63:0] dst;
    logic [31:0] size;
    logic [15:0] group;
  } st_entry_t;

  // Queue slot after head plus offset, wrapping at the queue depth.
  function automatic logic [QAW-1:0] wrap_add(input logic [QAW-1:0] head,
                                               input logic [QCW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(offs);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[QAW-1:0];
  endfunction

  state_e          state_q;
  in_word_t        cmd_q;
  logic [QAW-1:0]  ld_head_q, st_head_q;
  logic [QCW-1:0]  ld_count_q, st_count_q;
  logic [31:0]     ld_prog_q, st_prog_q;
  logic            out_valid_q;
  out_word_t       out_q, out_d;

  ld_entry_t       ld_mem [QUEUE_DEPTH];
  st_entry_t       st_mem [QUEUE_DEPTH];
  ld_entry_t       ld_rd_q;
  st_entry_t       st_rd_q;

  logic            in_accept, out_free, exec_go;
  logic            ld_full, st_full, ld_busy, st_busy;
  logic [QAW-1:0]  ld_tail, st_tail;
  logic [31:0]     ld_rem, st_rem, load_size;
  logic            ld_last, st_last;
  logic [4:0]      ld_len, st_len;

  // Handshake control.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign exec_go     = (state_q == S_EXEC) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Byte count of a load request, ready in the execute cycle.
  tcds_size_mul u_size_mul (
    .clk_i       (clk_i),
    .load_i      (in_accept),
    .elem_size_i (in_word_i.element_size),
    .dim_count_i (in_word_i.dim_count),
    .extent_a_i  (in_word_i.extent_a),
    .extent_b_i  (in_word_i.extent_b),
    .extent_c_i  (in_word_i.extent_c),
    .size_o      (load_size)
  );

  // Queue occupancy and tail slots.
  always_comb begin
    ld_full = (ld_count_q == QCW'(QUEUE_DEPTH));
    st_full = (st_count_q == QCW'(QUEUE_DEPTH));
    ld_busy = (ld_count_q != '0);
    st_busy = (st_count_q != '0);
    ld_tail = wrap_add(ld_head_q, ld_count_q);
    st_tail = wrap_add(st_head_q, st_count_q);
  end

  // Chunk length of each queue head; the last chunk finishes the request.
  always_comb begin
    ld_rem  = ld_rd_q.size - ld_prog_q;
    st_rem  = st_rd_q.size - st_prog_q;
    ld_last = (ld_rem <= 32'(CHUNK_BYTES));
    st_last = (st_rem <= 32'(CHUNK_BYTES));
    ld_len  = ld_last ? ld_rem[4:0] : 5'(CHUNK_BYTES);
    st_len  = st_last ? st_rem[4:0] : 5'(CHUNK_BYTES);
  end

  // Result word of the command in execution.
  always_comb begin
    out_d          = '0;
    out_d.accepted = 1'b1;
    case (cmd_q.operation)
      OP_LOAD: begin
        out_d.result_kind = KIND_ACK;
        out_d.accepted    = !ld_full;
      end
      OP_STORE: begin
        out_d.result_kind = KIND_ACK;
        out_d.accepted    = !st_full;
      end
      OP_CLEAR: begin
        out_d.result_kind = KIND_ACK;
      end
      default: begin
        if (ld_busy) begin
          out_d.result_kind  = KIND_LOAD;
          out_d.chunk_source = ld_rd_q.src + 64'(ld_prog_q);
          out_d.chunk_dest   = ld_rd_q.dst + 64'(ld_prog_q);
          out_d.chunk_length = ld_len;
          if (ld_last) begin
            out_d.request_done = 1'b1;
            out_d.done_tag     = ld_rd_q.tag[31:16];
            out_d.done_bytes   = ld_rd_q.size;
            out_d.ready_pipe   = ld_rd_q.tag[15:8];
            out_d.ready_stage  = ld_rd_q.tag[7:0];
          end
        end else if (st_busy) begin
          out_d.result_kind  = KIND_STORE;
          out_d.chunk_source = st_rd_q.src + 64'(st_prog_q);
          out_d.chunk_dest   = st_rd_q.dst + 64'(st_prog_q);
          out_d.chunk_length = st_len;
          if (st_last) begin
            out_d.request_done = 1'b1;
            out_d.done_tag     = st_rd_q.group;
          end
        end
      end
    endcase
  end

  // Command register, loaded on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= in_word_i;
    end
  end

  // Queue memories: written at the tail on enqueue, read at the head every
  // cycle. A write always returns the sequencer to idle, so the read for the
  // next executed word sees it.
  always_ff @(posedge clk_i) begin
    if (exec_go && (cmd_q.operation == OP_LOAD) && !ld_full) begin
      ld_mem[ld_tail] <= '{src:  cmd_q.source_address,
                           dst:  cmd_q.dest_address,
                           size: load_size,
                           tag:  {cmd_q.sync_tag, cmd_q.pipe_tag, cmd_q.stage_tag}};
    end
    ld_rd_q <= ld_mem[ld_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && (cmd_q.operation == OP_STORE) && !st_full) begin
      st_mem[st_tail] <= '{src:   cmd_q.source_address,
                           dst:   cmd_q.dest_address,
                           size:  cmd_q.store_length,
                           group: cmd_q.sync_tag};
    end
    st_rd_q <= st_mem[st_head_q];
  end

  // Sequencer, queue pointers, progress counters and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ld_head_q   <= '0;
      ld_count_q  <= '0;
      ld_prog_q   <= '0;
      st_head_q   <= '0;
      st_count_q  <= '0;
      st_prog_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (exec_go) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
            case (cmd_q.operation)
              OP_LOAD: begin
                if (!ld_full) begin
                  ld_count_q <= ld_count_q + QCW'(1);
                end
              end
              OP_STORE: begin
                if (!st_full) begin
                  st_count_q <= st_count_q + QCW'(1);
                end
              end
              OP_CLEAR: begin
                ld_head_q  <= '0;
                ld_count_q <= '0;
                ld_prog_q  <= '0;
                st_head_q  <= '0;
                st_count_q <= '0;
                st_prog_q  <= '0;
              end
              default: begin
                if (ld_busy) begin
                  if (ld_last) begin
                    ld_prog_q  <= '0;
                    ld_head_q  <= wrap_add(ld_head_q, QCW'(1));
                    ld_count_q <= ld_count_q - QCW'(1);
                  end else begin
                    ld_prog_q <= ld_prog_q + 32'(ld_len);
                  end
                end else if (st_busy) begin
                  if (st_last) begin
                    st_prog_q  <= '0;
                    st_head_q  <= wrap_add(st_head_q, QCW'(1));
                    st_count_q <= st_count_q - QCW'(1);
                  end else begin
                    st_prog_q <= st_prog_q + 32'(st_len);
                  end
                end
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/tcds_checker.sv
// Port-level checker for the tensor copy DMA scheduler, bound to the top
// level. Depends on tcds_pkg.
module tcds_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input tcds_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tcds_pkg::out_word_t out_word_o
);
  import tcds_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // The block is busy for the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // A fresh result always follows an accepted input word.
  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted input word");

  // An acknowledgment carries no chunk and no completion.
  a_ack_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind == KIND_ACK)
      |-> !out_word_o.request_done && (out_word_o.chunk_length == 5'd0))
    else $error("acknowledgment carries chunk data");

  // Store results report no done bytes and no ready pipe or stage.
  a_store_no_load_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind == KIND_STORE)
      |-> (out_word_o.done_bytes == 32'd0) && (out_word_o.ready_pipe == 8'd0)
          && (out_word_o.ready_stage == 8'd0))
    else $error("store chunk carries load completion fields");

endmodule

bind tensor_copy_dma_scheduler_unit tcds_checker u_tcds_checker (.*);
